// ----- sv/rgbpal_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbpal_pkg
// Shared types and register indexes for the nearest-ink 2bpp pixel packer.
// ----------------------------------------------------------------------------
package rgbpal_pkg;

  localparam int unsigned NumSlots    = 4;
  localparam int unsigned NumChannels = 3;
  localparam int unsigned NumLevels   = 3;

  // Square of an 8-bit difference, and a sum of three of them.
  typedef logic [15:0] sq_t;
  typedef logic [17:0] dist_t;
  typedef logic [4:0]  slot_t;

  // Squares indexed by channel (red, green, blue) and level (0, 128, 255).
  typedef sq_t   [NumLevels-1:0]   sq_lvl_t;
  typedef sq_lvl_t [NumChannels-1:0] sq_set_t;
  typedef dist_t [NumSlots-1:0]    dist_set_t;
  typedef slot_t [NumSlots-1:0]    slot_set_t;

  typedef enum logic [2:0] {
    CFG_DIRECT_MODE = 3'd0,
    CFG_INK_COUNT   = 3'd1,
    CFG_INK_SLOT_0  = 3'd2,
    CFG_INK_SLOT_1  = 3'd3,
    CFG_INK_SLOT_2  = 3'd4,
    CFG_INK_SLOT_3  = 3'd5
  } cfg_idx_e;

endpackage

// ----- sv/rgbpal_ink_dist.sv -----
// ----------------------------------------------------------------------------
// rgbpal_ink_dist
// Forms the squared RGB distance from one pixel to each palette slot colour.
// ----------------------------------------------------------------------------
module rgbpal_ink_dist import rgbpal_pkg::*; (
  input  sq_set_t   sq_i,
  input  slot_set_t slot_i,
  output dist_set_t dist_o
);

  // Hardware colour n = 9*g + 3*r + b; numbers above 26 read as 26.
  function automatic logic [5:0] colour_digits(logic [4:0] n);
    logic [4:0] c;
    logic [4:0] rem;
    logic [1:0] g;
    logic [1:0] r;
    logic [1:0] b;
    c = (n > 5'd26) ? 5'd26 : n;
    if (c >= 5'd18) begin
      g   = 2'd2;
      rem = c - 5'd18;
    end else if (c >= 5'd9) begin
      g   = 2'd1;
      rem = c - 5'd9;
    end else begin
      g   = 2'd0;
      rem = c;
    end
    if (rem >= 5'd6) begin
      r = 2'd2;
      b = 2'(rem - 5'd6);
    end else if (rem >= 5'd3) begin
      r = 2'd1;
      b = 2'(rem - 5'd3);
    end else begin
      r = 2'd0;
      b = 2'(rem);
    end
    return {g, r, b};
  endfunction

  always_comb begin
    logic [5:0] dig;
    for (int i = 0; i < NumSlots; i++) begin
      dig = colour_digits(slot_i[i]);
      dist_o[i] = 18'(sq_i[0][dig[3:2]]) + 18'(sq_i[1][dig[5:4]]) +
                  18'(sq_i[2][dig[1:0]]);
    end
  end

endmodule

// ----- sv/rgb_to_palette_2bpp_packer.sv -----
// ----------------------------------------------------------------------------
// rgb_to_palette_2bpp_packer
// Maps pixels to a 2-bit palette index and packs four of them per byte.
//
//   Channel  Signals                                  Direction
//   in       in_valid_i/in_ready_o, red/green/blue/   request in
//            pixel_index
//   out      out_valid_o/out_ready_i, sprite_byte,    request out
//            bad_index
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i        write only
//
// One pixel is accepted per clock while input ready is high. A pixel passes an
// input register, a square stage, a distance stage and the packing stage.
// Reset clears the packing state, the stage valids and the configuration
// registers. A stalled output fills the pipeline registers before input
// ready drops.
// ----------------------------------------------------------------------------
module rgb_to_palette_2bpp_packer import rgbpal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] pixel_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] sprite_byte_o,
  output logic       bad_index_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [4:0] cfg_data_i
);

  // Configuration registers.
  logic      direct_mode_q;
  logic [2:0] ink_count_q;
  slot_set_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_mode_q <= 1'b0;
      ink_count_q   <= 3'd4;
      slot_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIRECT_MODE: direct_mode_q <= cfg_data_i[0];
        CFG_INK_COUNT:   ink_count_q   <= cfg_data_i[2:0];
        CFG_INK_SLOT_0:  slot_q[0]     <= cfg_data_i;
        CFG_INK_SLOT_1:  slot_q[1]     <= cfg_data_i;
        CFG_INK_SLOT_2:  slot_q[2]     <= cfg_data_i;
        CFG_INK_SLOT_3:  slot_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valids and enables.
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_en, s2_en, s3_en, pack_en;
  logic out_valid_q, out_valid_d;

  assign pack_en    = s3_v_q && (!out_valid_q || out_ready_i);
  assign s3_en      = !s3_v_q || pack_en;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= in_valid_i;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
    end
  end

  // Stage 1: input register.
  logic [7:0] p_q [NumChannels];
  logic [7:0] idx1_q;

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      p_q[0] <= red_i;
      p_q[1] <= green_i;
      p_q[2] <= blue_i;
      idx1_q <= pixel_index_i;
    end
  end

  // Stage 2: squares of the channel distance to each of the three levels.
  sq_set_t   sq_d, sq_q;
  logic      bad2_q;
  logic [1:0] idx2_q;

  always_comb begin
    logic [7:0] dm;
    logic [7:0] dh;
    for (int c = 0; c < NumChannels; c++) begin
      dm = (p_q[c] >= 8'd128) ? (p_q[c] - 8'd128) : (8'd128 - p_q[c]);
      dh = 8'd255 - p_q[c];
      sq_d[c][0] = 16'(p_q[c]) * 16'(p_q[c]);
      sq_d[c][1] = 16'(dm) * 16'(dm);
      sq_d[c][2] = 16'(dh) * 16'(dh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      sq_q   <= sq_d;
      bad2_q <= (idx1_q >= 8'd4);
      idx2_q <= idx1_q[1:0];
    end
  end

  // Stage 3: distance to each slot.
  dist_set_t dist_d, dist_q;
  logic      bad3_q;
  logic [1:0] idx3_q;

  rgbpal_ink_dist u_ink_dist (
    .sq_i   (sq_q),
    .slot_i (slot_q),
    .dist_o (dist_d)
  );

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_v_q) begin
      dist_q <= dist_d;
      bad3_q <= bad2_q;
      idx3_q <= idx2_q;
    end
  end

  // Stage 4: pick the nearest ink (lowest slot on a tie) or direct index; pack.
  logic [NumSlots-1:0] active;
  logic       pick_hi01, pick_hi23, pick_hi;
  dist_t      best01, best23;
  logic [1:0] near_idx, pix_idx;

  always_comb begin
    active[0] = 1'b1;
    active[1] = (ink_count_q >= 3'd2);
    active[2] = (ink_count_q >= 3'd3);
    active[3] = (ink_count_q >= 3'd4);
    pick_hi01 = active[1] && (dist_q[1] < dist_q[0]);
    pick_hi23 = active[3] && (dist_q[3] < dist_q[2]);
    best01    = pick_hi01 ? dist_q[1] : dist_q[0];
    best23    = pick_hi23 ? dist_q[3] : dist_q[2];
    pick_hi   = active[2] && (best23 < best01);
    near_idx  = pick_hi ? {1'b1, pick_hi23} : {1'b0, pick_hi01};
    pix_idx   = direct_mode_q ? idx3_q : near_idx;
  end

  logic [1:0] pos_q, pos_d;
  logic [7:0] part_q, part_d;
  logic [7:0] packed_byte;
  logic       emit, bad_pix;
  logic [7:0] sprite_byte_q;
  logic       bad_index_q;

  always_comb begin
    bad_pix     = direct_mode_q && bad3_q;
    packed_byte = {part_q[6:0], 1'b0} | {3'b000, pix_idx[0], 3'b000, pix_idx[1]};
    emit        = bad_pix || (pos_q == 2'd3);
    if (emit) begin
      pos_d  = 2'd0;
      part_d = 8'd0;
    end else begin
      pos_d  = pos_q + 2'd1;
      part_d = packed_byte;
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || (pack_en && emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      part_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pack_en) begin
        pos_q  <= pos_d;
        part_q <= part_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pack_en && emit) begin
      sprite_byte_q <= bad_pix ? 8'd0 : packed_byte;
      bad_index_q   <= bad_pix;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sprite_byte_o = sprite_byte_q;
  assign bad_index_o   = bad_index_q;

endmodule

// ----- sv/rgbpal_checker.sv -----
// ----------------------------------------------------------------------------
// rgbpal_checker
// Port-level checks for the nearest-ink 2bpp pixel packer.
// ----------------------------------------------------------------------------
module rgbpal_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] pixel_index_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] sprite_byte_o,
  input logic       bad_index_o,
  input logic       cfg_we_i,
  input logic [2:0] cfg_index_i,
  input logic [4:0] cfg_data_i
);

  // A flagged index always carries an empty byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> sprite_byte_o == 8'd0)
    else $error("bad index request with nonzero byte");

  // With the output free the pipeline always has room for a new pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output request dropped before acceptance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sprite_byte_o) && $stable(bad_index_o))
    else $error("output payload changed while stalled");

endmodule

bind rgb_to_palette_2bpp_packer rgbpal_checker u_rgbpal_checker (.*);
